[hw/rtl/brute_force_top_k_vector_search_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the top-k vector search block
// Concurrent checks clocked on clock and held off during reset.
// ----------------------------------------------------------------------------
`ifndef BRUTE_FORCE_TOP_K_VECTOR_SEARCH_ASSERT_SVH
`define BRUTE_FORCE_TOP_K_VECTOR_SEARCH_ASSERT_SVH

// same-cycle implication
`define BFKV_ASSERT_SAME(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error("bfkv check failed");

// next-cycle implication
`define BFKV_ASSERT_NEXT(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error("bfkv check failed");

`endif

[hw/rtl/bfkv_pkg.sv]
// ----------------------------------------------------------------------------
// bfkv_pkg
// Sizes, codes and shared types of the top-k vector search block.
// ----------------------------------------------------------------------------
`default_nettype none

package bfkv_pkg;

   localparam int STORE_CAPACITY = 1024;
   localparam int MAX_LENGTH     = 128;
   localparam int MAX_NEIGHBOURS = 16;
   localparam int RESULT_LIMIT   = 16;
   localparam int K_MAX = (MAX_NEIGHBOURS < RESULT_LIMIT) ? MAX_NEIGHBOURS : RESULT_LIMIT;

   localparam int OP_W     = 2;
   localparam int ID_W     = 32;
   localparam int VAL_W    = 16;
   localparam int KIN_W    = 5;
   localparam int DIST_W   = 48;
   localparam int ST_W     = 3;
   localparam int CFG_W    = 8;
   localparam int METRIC_W = 2;

   localparam int POS_W  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int LEN_W  = $clog2(MAX_LENGTH + 1);
   localparam int SLOT_W = (STORE_CAPACITY > 1) ? $clog2(STORE_CAPACITY) : 1;
   localparam int CNT_W  = $clog2(STORE_CAPACITY + 1);
   localparam int K_W    = $clog2(K_MAX + 1);
   localparam int KI_W   = (K_MAX > 1) ? $clog2(K_MAX) : 1;

   // accumulator and cosine datapath widths
   localparam int DOT_W     = 2 * VAL_W + LEN_W;
   localparam int NRM_W     = 2 * VAL_W - 1 + LEN_W;
   localparam int HALF_W    = (NRM_W + 1) / 2;
   localparam int PROD_W    = 2 * NRM_W;
   localparam int ROOT_W    = NRM_W;
   localparam int FRAC_BITS = 30;
   localparam int QUO_W     = FRAC_BITS + 1;

   localparam int CMDQ_DEPTH = 2;
   localparam int OUTQ_DEPTH = 4;

   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [ST_W-1:0] ST_NEIGHBOUR = 3'd0;
   localparam logic [ST_W-1:0] ST_STORED    = 3'd1;
   localparam logic [ST_W-1:0] ST_NONE      = 3'd2;
   localparam logic [ST_W-1:0] ST_MISMATCH  = 3'd3;
   localparam logic [ST_W-1:0] ST_FULL      = 3'd4;
   localparam logic [ST_W-1:0] ST_CLEARED   = 3'd5;

   localparam logic CSR_LENGTH = 1'b0;
   localparam logic CSR_METRIC = 1'b1;

   localparam logic [METRIC_W-1:0] METRIC_COSINE = 2'd1;
   localparam logic [METRIC_W-1:0] METRIC_DOT    = 2'd2;

   typedef struct packed {
      logic             search;
      logic [ST_W-1:0]  status;
      logic [K_W-1:0]   k;
      logic [CNT_W-1:0] count;
   } cmd_type;

   typedef struct packed {
      logic                    vec_we;
      logic [SLOT_W+POS_W-1:0] vec_addr;
      logic [VAL_W-1:0]        vec_data;
      logic                    qry_we;
      logic [POS_W-1:0]        qry_addr;
      logic                    id_we;
      logic [SLOT_W-1:0]       id_addr;
      logic [ID_W-1:0]         id_data;
   } wr_type;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [DIST_W-1:0] distance;
      logic [ST_W-1:0]   status;
      logic              last;
   } rsp_type;

endpackage

`default_nettype wire

[hw/rtl/bfkv_front.sv]
// ----------------------------------------------------------------------------
// bfkv_front
// Request intake: component counting, store writes and command issue.
// ----------------------------------------------------------------------------
`default_nettype none

module bfkv_front
   import bfkv_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   output logic                         full,
   input  wire logic [OP_W-1:0]         req_opcode,
   input  wire logic [ID_W-1:0]         req_vector_id,
   input  wire logic signed [VAL_W-1:0] req_element_value,
   input  wire logic                    req_element_last,
   input  wire logic [KIN_W-1:0]        req_neighbours_wanted,
   input  wire logic [CFG_W-1:0]        cfg_length,
   input  wire logic                    cmdq_full,
   input  wire logic                    srch_done,
   output logic                         cmd_push,
   output cmd_type                      cmd,
   output wr_type                       wr
);

   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] stored_ff, stored_in;
   logic             srch_ff, srch_in;

   logic             accept;
   logic             in_range;
   logic             store_full;
   logic             len_ok;
   logic [K_W-1:0]   k_sat;

   assign full       = cmdq_full | srch_ff;
   assign accept     = push & ~full;
   assign in_range   = 32'(cnt_ff) < 32'(MAX_LENGTH);
   assign store_full = 32'(stored_ff) >= 32'(STORE_CAPACITY);
   assign len_ok     = (cfg_length != '0) && (32'(cfg_length) <= 32'(MAX_LENGTH)) &&
                       ((32'(cnt_ff) + 32'd1) == 32'(cfg_length));
   assign k_sat      = (32'(req_neighbours_wanted) > 32'(K_MAX)) ? K_W'(K_MAX)
                                                                 : K_W'(req_neighbours_wanted);

   always_comb begin
      cnt_in      = cnt_ff;
      stored_in   = stored_ff;
      srch_in     = srch_ff & ~srch_done;
      cmd_push    = 1'b0;
      cmd.search  = 1'b0;
      cmd.status  = ST_NONE;
      cmd.k       = k_sat;
      cmd.count   = stored_ff;
      wr.vec_we   = accept && (req_opcode == OP_ADD) && in_range && !store_full;
      wr.vec_addr = {stored_ff[SLOT_W-1:0], cnt_ff[POS_W-1:0]};
      wr.vec_data = req_element_value;
      wr.qry_we   = accept && (req_opcode == OP_QUERY) && in_range;
      wr.qry_addr = cnt_ff[POS_W-1:0];
      wr.id_we    = 1'b0;
      wr.id_addr  = stored_ff[SLOT_W-1:0];
      wr.id_data  = req_vector_id;
      if (accept) begin
         unique case (req_opcode)
            OP_CLEAR: begin
               stored_in  = '0;
               cnt_in     = '0;
               cmd_push   = 1'b1;
               cmd.status = ST_CLEARED;
            end
            OP_ADD, OP_QUERY: begin
               if (!req_element_last) begin
                  cnt_in = in_range ? cnt_ff + LEN_W'(1) : cnt_ff;
               end else begin
                  cnt_in   = '0;
                  cmd_push = 1'b1;
                  if (!len_ok) begin
                     cmd.status = ST_MISMATCH;
                  end else if (req_opcode == OP_ADD) begin
                     if (store_full) begin
                        cmd.status = ST_FULL;
                     end else begin
                        stored_in  = stored_ff + CNT_W'(1);
                        wr.id_we   = 1'b1;
                        cmd.status = ST_STORED;
                     end
                  end else if (k_sat == '0 || stored_ff == '0) begin
                     cmd.status = ST_NONE;
                  end else begin
                     cmd.search = 1'b1;
                     cmd.status = ST_NEIGHBOUR;
                     srch_in    = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         stored_ff <= '0;
         srch_ff   <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         stored_ff <= stored_in;
         srch_ff   <= srch_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/bfkv_cmdq.sv]
// ----------------------------------------------------------------------------
// bfkv_cmdq
// Short command queue between request intake and the search engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bfkv_cmdq
   import bfkv_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type din,
   input  wire logic    pop,
   output logic         valid,
   output logic         full,
   output cmd_type      dout
);

   localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CW = $clog2(CMDQ_DEPTH + 1);

   cmd_type         q_mem [CMDQ_DEPTH];
   logic [PW-1:0]   wp_ff, rp_ff;
   logic [CW-1:0]   cnt_ff;
   logic            do_push, do_pop;

   assign valid   = cnt_ff != '0;
   assign full    = 32'(cnt_ff) == 32'(CMDQ_DEPTH);
   assign dout    = q_mem[rp_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_mem[wp_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wp_ff <= (32'(wp_ff) == CMDQ_DEPTH - 1) ? '0 : wp_ff + PW'(1);
         end
         if (do_pop) begin
            rp_ff <= (32'(rp_ff) == CMDQ_DEPTH - 1) ? '0 : rp_ff + PW'(1);
         end
         cnt_ff <= cnt_ff + CW'(do_push) - CW'(do_pop);
      end
   end

endmodule

`default_nettype wire

[hw/rtl/bfkv_back.sv]
// ----------------------------------------------------------------------------
// bfkv_back
// Search engine: stores, distance scan, top-k list and result queue.
// ----------------------------------------------------------------------------
`default_nettype none
`include "brute_force_top_k_vector_search_assert.svh"

module bfkv_back
   import bfkv_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire wr_type                wr,
   input  wire logic [CFG_W-1:0]      cfg_length,
   input  wire logic [METRIC_W-1:0]   cfg_metric,
   input  wire logic                  cmd_valid,
   input  wire cmd_type               cmd,
   output logic                       cmd_pop,
   output logic                       srch_done,
   input  wire logic                  pop,
   output logic                       empty,
   output logic [ID_W-1:0]            rsp_result_id,
   output logic signed [DIST_W-1:0]   rsp_distance,
   output logic [ST_W-1:0]            rsp_status,
   output logic                       rsp_result_last
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ACC  = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_SQRT = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_INS  = 3'd5;
   localparam logic [2:0] S_EMIT = 3'd6;

   localparam int VMEM_DEPTH = 2 ** (SLOT_W + POS_W);
   localparam int SREM_W = ROOT_W + 3;
   localparam int DREM_W = ROOT_W + 2;
   localparam int SCNT_W = $clog2(ROOT_W);
   localparam int DCNT_W = $clog2(QUO_W);
   localparam int OQ_PW  = $clog2(OUTQ_DEPTH);
   localparam int OQ_CW  = $clog2(OUTQ_DEPTH + 1);
   localparam logic signed [DIST_W-1:0] ONE_Q30 = DIST_W'(1) << FRAC_BITS;

   // stores
   logic signed [VAL_W-1:0] vmem [VMEM_DEPTH];
   logic signed [VAL_W-1:0] qmem [2 ** POS_W];
   logic [ID_W-1:0]         imem [2 ** SLOT_W];
   logic signed [VAL_W-1:0] vrd_ff, qrd_ff;
   logic [ID_W-1:0]         ird_ff;

   // control
   logic [2:0]       state_ff, state_in;
   logic [K_W-1:0]   k_ff, k_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] slot_ff, slot_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic             p1_ff, p1_in, p2_ff, p2_in;
   logic [K_W-1:0]   n_ff, n_in;
   logic [KI_W-1:0]  eidx_ff, eidx_in;
   logic [2:0]       mcnt_ff, mcnt_in;
   logic [SCNT_W-1:0] scnt_ff, scnt_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;

   // datapath
   logic signed [2*VAL_W-1:0] dotp_ff;
   logic [2*VAL_W-1:0]        l2p_ff;
   logic [2*VAL_W-2:0]        nqp_ff, ntp_ff;
   logic signed [DOT_W-1:0]   dot_ff, dot_in;
   logic [DOT_W-1:0]          l2_ff, l2_in;
   logic [NRM_W-1:0]          nq_ff, nq_in, nt_ff, nt_in;
   logic [2*HALF_W-1:0]       pp_ff, pp_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [PROD_W-1:0]         sp_ff, sp_in;
   logic [ROOT_W-1:0]         root_ff, root_in;
   logic [SREM_W-1:0]         srem_ff, srem_in;
   logic [DREM_W-1:0]         drem_ff, drem_in;
   logic [QUO_W-1:0]          quo_ff, quo_in;
   logic signed [DIST_W-1:0]  key_ff, key_in;
   logic signed [DIST_W-1:0]  bkey_ff [K_MAX];
   logic signed [DIST_W-1:0]  bkey_in [K_MAX];
   logic [ID_W-1:0]           bid_ff [K_MAX];
   logic [ID_W-1:0]           bid_in [K_MAX];

   // products of the current component pair
   logic signed [VAL_W:0]     dif_c;
   logic signed [2*VAL_W+1:0] dsq_c;
   logic signed [2*VAL_W-1:0] qq_c, vv_c, qv_c;

   // cosine helpers
   logic [HALF_W-1:0]   ma_c, mb_c;
   logic [1:0]          pair_c;
   logic [SREM_W-1:0]   srem2_c, strial_c;
   logic [DREM_W-1:0]   drs_c;
   logic                dge_c;
   logic [DOT_W-1:0]    dabs_c;

   logic [K_MAX-1:0]    le_c;
   logic [K_MAX:0]      lex_c;
   logic                ins_ok;
   logic [KI_W-1:0]     klast_c;

   // output queue
   rsp_type             oq_mem [OUTQ_DEPTH];
   logic [OQ_PW-1:0]    oq_wp_ff, oq_rp_ff;
   logic [OQ_CW-1:0]    oq_cnt_ff;
   logic                oq_full, oq_push, oq_pop, emit_last;
   rsp_type             oq_din;

   always_ff @(posedge clock) begin
      if (wr.vec_we) begin
         vmem[wr.vec_addr] <= wr.vec_data;
      end
      if (wr.qry_we) begin
         qmem[wr.qry_addr] <= wr.vec_data;
      end
      if (wr.id_we) begin
         imem[wr.id_addr] <= wr.id_data;
      end
      vrd_ff <= vmem[{slot_ff[SLOT_W-1:0], idx_ff[POS_W-1:0]}];
      qrd_ff <= qmem[idx_ff[POS_W-1:0]];
      ird_ff <= imem[slot_ff[SLOT_W-1:0]];
   end

   assign dif_c = {qrd_ff[VAL_W-1], qrd_ff} - {vrd_ff[VAL_W-1], vrd_ff};
   assign dsq_c = dif_c * dif_c;
   assign qq_c  = qrd_ff * qrd_ff;
   assign vv_c  = vrd_ff * vrd_ff;
   assign qv_c  = qrd_ff * vrd_ff;

   assign oq_full   = 32'(oq_cnt_ff) == 32'(OUTQ_DEPTH);
   assign empty     = oq_cnt_ff == '0;
   assign oq_pop    = pop & ~empty;
   assign emit_last = (K_W'(eidx_ff) + K_W'(1)) == n_ff;
   assign klast_c   = KI_W'(k_ff - K_W'(1));
   assign pair_c    = mcnt_ff[1:0] - 2'd1;

   assign rsp_result_id   = oq_mem[oq_rp_ff].id;
   assign rsp_distance    = oq_mem[oq_rp_ff].distance;
   assign rsp_status      = oq_mem[oq_rp_ff].status;
   assign rsp_result_last = oq_mem[oq_rp_ff].last;

   // sorted insert: entries at or below the new key stay, the rest move down
   always_comb begin
      for (int j = 0; j < K_MAX; j++) begin
         le_c[j] = (K_W'(j) < n_ff) && (bkey_ff[j] <= key_ff);
      end
      lex_c  = {le_c, 1'b1};
      ins_ok = !le_c[klast_c];
   end

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      cnt_in    = cnt_ff;
      slot_in   = slot_ff;
      idx_in    = idx_ff;
      p1_in     = 1'b0;
      p2_in     = p1_ff;
      n_in      = n_ff;
      eidx_in   = eidx_ff;
      mcnt_in   = mcnt_ff;
      scnt_in   = scnt_ff;
      dcnt_in   = dcnt_ff;
      dot_in    = dot_ff;
      l2_in     = l2_ff;
      nq_in     = nq_ff;
      nt_in     = nt_ff;
      pp_in     = pp_ff;
      prod_in   = prod_ff;
      sp_in     = sp_ff;
      root_in   = root_ff;
      srem_in   = srem_ff;
      drem_in   = drem_ff;
      quo_in    = quo_ff;
      key_in    = key_ff;
      cmd_pop   = 1'b0;
      srch_done = 1'b0;
      oq_push   = 1'b0;
      oq_din.id       = '0;
      oq_din.distance = '0;
      oq_din.status   = cmd.status;
      oq_din.last     = 1'b1;
      ma_c     = '0;
      mb_c     = '0;
      srem2_c  = '0;
      strial_c = '0;
      drs_c    = '0;
      dge_c    = 1'b0;
      dabs_c   = dot_ff[DOT_W-1] ? DOT_W'(-dot_ff) : DOT_W'(dot_ff);
      for (int j = 0; j < K_MAX; j++) begin
         bkey_in[j] = bkey_ff[j];
         bid_in[j]  = bid_ff[j];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               if (cmd.search) begin
                  cmd_pop  = 1'b1;
                  k_in     = cmd.k;
                  cnt_in   = cmd.count;
                  slot_in  = '0;
                  n_in     = '0;
                  idx_in   = '0;
                  dot_in   = '0;
                  l2_in    = '0;
                  nq_in    = '0;
                  nt_in    = '0;
                  state_in = S_ACC;
               end else if (!oq_full) begin
                  cmd_pop = 1'b1;
                  oq_push = 1'b1;
               end
            end
         end
         S_ACC: begin
            if (32'(idx_ff) < 32'(cfg_length)) begin
               idx_in = idx_ff + LEN_W'(1);
               p1_in  = 1'b1;
            end
            if (p2_ff) begin
               dot_in = dot_ff + DOT_W'(dotp_ff);
               l2_in  = l2_ff + DOT_W'(l2p_ff);
               nq_in  = nq_ff + NRM_W'(nqp_ff);
               nt_in  = nt_ff + NRM_W'(ntp_ff);
            end
            if ((32'(idx_ff) >= 32'(cfg_length)) && !p1_ff && !p2_ff) begin
               if (cfg_metric == METRIC_COSINE) begin
                  mcnt_in  = '0;
                  prod_in  = '0;
                  state_in = S_MUL;
               end else if (cfg_metric == METRIC_DOT) begin
                  key_in   = -(DIST_W'(dot_ff));
                  state_in = S_INS;
               end else begin
                  key_in   = DIST_W'(l2_ff);
                  state_in = S_INS;
               end
            end
         end
         S_MUL: begin
            // |q|^2 * |t|^2 from four half-width partial products
            unique case (mcnt_ff[1:0])
               2'd0: begin ma_c = nq_ff[HALF_W-1:0];       mb_c = nt_ff[HALF_W-1:0];       end
               2'd1: begin ma_c = nq_ff[HALF_W-1:0];       mb_c = HALF_W'(nt_ff >> HALF_W); end
               2'd2: begin ma_c = HALF_W'(nq_ff >> HALF_W); mb_c = nt_ff[HALF_W-1:0];       end
               default: begin
                  ma_c = HALF_W'(nq_ff >> HALF_W);
                  mb_c = HALF_W'(nt_ff >> HALF_W);
               end
            endcase
            pp_in = ma_c * mb_c;
            if (mcnt_ff != '0) begin
               unique case (pair_c)
                  2'd0:    prod_in = prod_ff + PROD_W'(pp_ff);
                  2'd3:    prod_in = prod_ff + (PROD_W'(pp_ff) << (2 * HALF_W));
                  default: prod_in = prod_ff + (PROD_W'(pp_ff) << HALF_W);
               endcase
            end
            mcnt_in = mcnt_ff + 3'd1;
            if (mcnt_ff == 3'd4) begin
               sp_in    = prod_in;
               root_in  = '0;
               srem_in  = '0;
               scnt_in  = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            // one root bit per cycle
            srem2_c  = {srem_ff[SREM_W-3:0], sp_ff[PROD_W-1 -: 2]};
            strial_c = SREM_W'({root_ff, 2'b01});
            if (srem2_c >= strial_c) begin
               srem_in = srem2_c - strial_c;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = srem2_c;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            sp_in   = sp_ff << 2;
            scnt_in = scnt_ff + SCNT_W'(1);
            if (32'(scnt_ff) == ROOT_W - 1) begin
               if (root_in == '0) begin
                  key_in   = ONE_Q30;
                  state_in = S_INS;
               end else begin
                  drem_in  = (dabs_c > DOT_W'(root_in)) ? DREM_W'(root_in) : DREM_W'(dabs_c);
                  quo_in   = '0;
                  dcnt_in  = '0;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            // one quotient bit per cycle
            drs_c   = (dcnt_ff == '0) ? drem_ff : {drem_ff[DREM_W-2:0], 1'b0};
            dge_c   = drs_c >= DREM_W'(root_ff);
            drem_in = dge_c ? drs_c - DREM_W'(root_ff) : drs_c;
            quo_in  = {quo_ff[QUO_W-2:0], dge_c};
            dcnt_in = dcnt_ff + DCNT_W'(1);
            if (32'(dcnt_ff) == QUO_W - 1) begin
               key_in   = dot_ff[DOT_W-1] ? ONE_Q30 + DIST_W'(quo_in)
                                          : ONE_Q30 - DIST_W'(quo_in);
               state_in = S_INS;
            end
         end
         S_INS: begin
            if (ins_ok) begin
               for (int j = 0; j < K_MAX; j++) begin
                  if (!le_c[j]) begin
                     if (lex_c[j]) begin
                        bkey_in[j] = key_ff;
                        bid_in[j]  = ird_ff;
                     end else begin
                        bkey_in[j] = bkey_ff[(j > 0) ? j - 1 : 0];
                        bid_in[j]  = bid_ff[(j > 0) ? j - 1 : 0];
                     end
                  end
               end
               if (n_ff < k_ff) begin
                  n_in = n_ff + K_W'(1);
               end
            end
            if (slot_ff + CNT_W'(1) == cnt_ff) begin
               eidx_in  = '0;
               state_in = S_EMIT;
            end else begin
               slot_in  = slot_ff + CNT_W'(1);
               idx_in   = '0;
               dot_in   = '0;
               l2_in    = '0;
               nq_in    = '0;
               nt_in    = '0;
               state_in = S_ACC;
            end
         end
         S_EMIT: begin
            oq_din.id       = bid_ff[eidx_ff];
            oq_din.distance = (cfg_metric == METRIC_DOT) ? -bkey_ff[eidx_ff] : bkey_ff[eidx_ff];
            oq_din.status   = ST_NEIGHBOUR;
            oq_din.last     = emit_last;
            if (!oq_full) begin
               oq_push = 1'b1;
               eidx_in = eidx_ff + KI_W'(1);
               if (emit_last) begin
                  srch_done = 1'b1;
                  state_in  = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         k_ff      <= '0;
         cnt_ff    <= '0;
         slot_ff   <= '0;
         idx_ff    <= '0;
         p1_ff     <= 1'b0;
         p2_ff     <= 1'b0;
         n_ff      <= '0;
         eidx_ff   <= '0;
         mcnt_ff   <= '0;
         scnt_ff   <= '0;
         dcnt_ff   <= '0;
         oq_wp_ff  <= '0;
         oq_rp_ff  <= '0;
         oq_cnt_ff <= '0;
      end else begin
         state_ff  <= state_in;
         k_ff      <= k_in;
         cnt_ff    <= cnt_in;
         slot_ff   <= slot_in;
         idx_ff    <= idx_in;
         p1_ff     <= p1_in;
         p2_ff     <= p2_in;
         n_ff      <= n_in;
         eidx_ff   <= eidx_in;
         mcnt_ff   <= mcnt_in;
         scnt_ff   <= scnt_in;
         dcnt_ff   <= dcnt_in;
         if (oq_push) begin
            oq_wp_ff <= (32'(oq_wp_ff) == OUTQ_DEPTH - 1) ? '0 : oq_wp_ff + OQ_PW'(1);
         end
         if (oq_pop) begin
            oq_rp_ff <= (32'(oq_rp_ff) == OUTQ_DEPTH - 1) ? '0 : oq_rp_ff + OQ_PW'(1);
         end
         oq_cnt_ff <= oq_cnt_ff + OQ_CW'(oq_push) - OQ_CW'(oq_pop);
      end
   end

   always_ff @(posedge clock) begin
      dotp_ff <= qv_c;
      l2p_ff  <= dsq_c[2*VAL_W-1:0];
      nqp_ff  <= qq_c[2*VAL_W-2:0];
      ntp_ff  <= vv_c[2*VAL_W-2:0];
      dot_ff  <= dot_in;
      l2_ff   <= l2_in;
      nq_ff   <= nq_in;
      nt_ff   <= nt_in;
      pp_ff   <= pp_in;
      prod_ff <= prod_in;
      sp_ff   <= sp_in;
      root_ff <= root_in;
      srem_ff <= srem_in;
      drem_ff <= drem_in;
      quo_ff  <= quo_in;
      key_ff  <= key_in;
      for (int j = 0; j < K_MAX; j++) begin
         bkey_ff[j] <= bkey_in[j];
         bid_ff[j]  <= bid_in[j];
      end
      if (oq_push) begin
         oq_mem[oq_wp_ff] <= oq_din;
      end
   end

   `BFKV_ASSERT_SAME(a_best_within_k, 1'b1, n_ff <= k_ff)
   `BFKV_ASSERT_SAME(a_scan_in_store, state_ff == S_ACC, slot_ff < cnt_ff)
   `BFKV_ASSERT_NEXT(a_emit_ends, (state_ff == S_EMIT) && oq_push && emit_last, state_ff == S_IDLE)
   `BFKV_ASSERT_SAME(a_outq_bound, 1'b1, 32'(oq_cnt_ff) <= 32'(OUTQ_DEPTH))

endmodule

`default_nettype wire

[hw/rtl/brute_force_top_k_vector_search.sv]
// A store, status or clear result passes the command queue and then the result queue on its
//   way to the ports, and it waits behind earlier results that are still to be popped.
// Throughput: components load one per cycle while intake is not full; a query scans every
//   stored vector in turn for squared L2 and dot product, and for cosine adds a partial-product
//   multiply, bit-serial root and divide per entry. Up to k neighbours then leave one per
//   cycle while the result queue has room; intake stalls until a search has finished.
// Reset is synchronous and empties the store, counters, queues and neighbour list at once.
// ----------------------------------------------------------------------------
// brute_force_top_k_vector_search
// Exhaustive k-nearest search over id-tagged vectors loaded one component per request.
// ----------------------------------------------------------------------------
`default_nettype none

module brute_force_top_k_vector_search
   import bfkv_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request side
   input  wire logic                    push,
   output logic                         full,
   input  wire logic [OP_W-1:0]         req_opcode,
   input  wire logic [ID_W-1:0]         req_vector_id,
   input  wire logic signed [VAL_W-1:0] req_element_value,
   input  wire logic                    req_element_last,
   input  wire logic [KIN_W-1:0]        req_neighbours_wanted,
   // result side
   output logic                         empty,
   input  wire logic                    pop,
   output logic [ID_W-1:0]              rsp_result_id,
   output logic signed [DIST_W-1:0]     rsp_distance,
   output logic [ST_W-1:0]              rsp_status,
   output logic                         rsp_result_last,
   // configuration
   input  wire logic                    csr_we,
   input  wire logic                    csr_index,
   input  wire logic [CFG_W-1:0]        csr_wdata
);

   logic [CFG_W-1:0]    length_ff;
   logic [METRIC_W-1:0] metric_ff;

   cmd_type fe_cmd, q_cmd;
   wr_type  fe_wr;
   logic    fe_push, q_full, q_valid, be_pop, be_done;

   // hold configuration; the user must make changes only while the block is idle, as the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= CFG_W'(MAX_LENGTH);
         metric_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LENGTH: length_ff <= csr_wdata;
            CSR_METRIC: metric_ff <= csr_wdata[METRIC_W-1:0];
            default:    length_ff <= length_ff;
         endcase
      end
   end

   // front: count components, write stores, issue one command per finished request
   bfkv_front u_front (
      .clock                 (clock),
      .reset                 (reset),
      .push                  (push),
      .full                  (full),
      .req_opcode            (req_opcode),
      .req_vector_id         (req_vector_id),
      .req_element_value     (req_element_value),
      .req_element_last      (req_element_last),
      .req_neighbours_wanted (req_neighbours_wanted),
      .cfg_length            (length_ff),
      .cmdq_full             (q_full),
      .srch_done             (be_done),
      .cmd_push              (fe_push),
      .cmd                   (fe_cmd),
      .wr                    (fe_wr)
   );

   // decouple intake from the scan
   bfkv_cmdq u_cmdq (
      .clock (clock),
      .reset (reset),
      .push  (fe_push),
      .din   (fe_cmd),
      .pop   (be_pop),
      .valid (q_valid),
      .full  (q_full),
      .dout  (q_cmd)
   );

   // back: answer status commands, run searches, queue results
   bfkv_back u_back (
      .clock           (clock),
      .reset           (reset),
      .wr              (fe_wr),
      .cfg_length      (length_ff),
      .cfg_metric      (metric_ff),
      .cmd_valid       (q_valid),
      .cmd             (q_cmd),
      .cmd_pop         (be_pop),
      .srch_done       (be_done),
      .pop             (pop),
      .empty           (empty),
      .rsp_result_id   (rsp_result_id),
      .rsp_distance    (rsp_distance),
      .rsp_status      (rsp_status),
      .rsp_result_last (rsp_result_last)
   );

endmodule

`default_nettype wire
